FILE: design/lanczos2_decimate_by_two_unit_macros.svh
// Assertion macros used by the top-level file to check its own logic.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LANCZOS2_DECIMATE_BY_TWO_UNIT_MACROS_SVH
`define LANCZOS2_DECIMATE_BY_TWO_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define L2DEC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("l2dec: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define L2DEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("l2dec: next-cycle check failed");

`else

`define L2DEC_ASSERT_IMPLY(label, ante, cons)
`define L2DEC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/l2dec_pkg.sv
package l2dec_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LEN_BITS = 13;
  localparam int MAX_LINE_LENGTH_DEFAULT = 4096;
  localparam int MIN_LINE_LENGTH = 8;

  localparam int TAPS = 8;
  localparam int WIN_IDX_W = $clog2(TAPS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // Datapath widths: pre-added pair, constant product, accumulator, rounded value.
  localparam int PRE_W = SAMPLE_BITS + 1;
  localparam int COEF_W = 16;
  localparam int PROD_W = PRE_W + COEF_W;
  localparam int ACC_W = PROD_W + 2;
  localparam int FRAC_BITS = 15;
  localparam int RND_W = ACC_W - FRAC_BITS;
  localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);
  localparam int SAT_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAT_MIN = -(1 << (SAMPLE_BITS - 1));

  // Q1.15 taps of the symmetric kernel, outermost pair first.
  localparam logic signed [COEF_W-1:0] COEF0 = -16'sd295;
  localparam logic signed [COEF_W-1:0] COEF1 = -16'sd1376;
  localparam logic signed [COEF_W-1:0] COEF2 = 16'sd3834;
  localparam logic signed [COEF_W-1:0] COEF3 = 16'sd14221;

  // Kind of a queued entry, decided by the front end.
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_NORM     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FIRST    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SECOND   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END_EVEN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END_ODD  = 3'd4;

  // Window read pattern of one result.
  localparam int PAT_W = 3;
  localparam logic [PAT_W-1:0] PAT_NORM   = 3'd0;
  localparam logic [PAT_W-1:0] PAT_FIRST  = 3'd1;
  localparam logic [PAT_W-1:0] PAT_SECOND = 3'd2;
  localparam logic [PAT_W-1:0] PAT_EVEN_A = 3'd3;
  localparam logic [PAT_W-1:0] PAT_EVEN_B = 3'd4;
  localparam logic [PAT_W-1:0] PAT_ODD_B  = 3'd5;

  // Window age read by tap k, tap 0 in the low bits. Mirrored edges fold
  // indices back onto samples that are still in the window.
  localparam logic [TAPS-1:0][WIN_IDX_W-1:0] MAP_NORM =
    {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
  localparam logic [TAPS-1:0][WIN_IDX_W-1:0] MAP_FIRST =
    {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd3, 3'd2, 3'd1};
  localparam logic [TAPS-1:0][WIN_IDX_W-1:0] MAP_SECOND =
    {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd5};
  localparam logic [TAPS-1:0][WIN_IDX_W-1:0] MAP_EVEN_A =
    {3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};
  localparam logic [TAPS-1:0][WIN_IDX_W-1:0] MAP_EVEN_B =
    {3'd2, 3'd1, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4};
  localparam logic [TAPS-1:0][WIN_IDX_W-1:0] MAP_ODD_B =
    {3'd1, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};

  typedef logic [TAPS-1:0][SAMPLE_BITS-1:0] window_t;

  typedef struct packed {
    window_t           win;
    logic [KIND_W-1:0] kind;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  function automatic logic [TAPS-1:0][WIN_IDX_W-1:0] pat_map(input logic [PAT_W-1:0] pat);
    logic [TAPS-1:0][WIN_IDX_W-1:0] m;
    case (pat)
      PAT_NORM:   m = MAP_NORM;
      PAT_FIRST:  m = MAP_FIRST;
      PAT_SECOND: m = MAP_SECOND;
      PAT_EVEN_A: m = MAP_EVEN_A;
      PAT_EVEN_B: m = MAP_EVEN_B;
      PAT_ODD_B:  m = MAP_ODD_B;
      default:    m = MAP_NORM;
    endcase
    return m;
  endfunction

endpackage

FILE: design/l2dec_front.sv
module l2dec_front #(
  parameter int MAX_LINE_LENGTH = l2dec_pkg::MAX_LINE_LENGTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [l2dec_pkg::LEN_BITS-1:0]     cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [l2dec_pkg::SAMPLE_BITS-1:0]  s_tdata,
  input  logic                               q_full,
  output l2dec_pkg::push_t                   push_o
);

  localparam int POS_W = $clog2(MAX_LINE_LENGTH);

  logic [POS_W-1:0]          pos;
  logic [POS_W-1:0]          line_last;
  logic [POS_W-1:0]          line_last_next;
  l2dec_pkg::window_t        win;
  l2dec_pkg::window_t        win_next;
  logic                      accept;
  logic                      emit;
  logic [l2dec_pkg::KIND_W-1:0] kind;
  logic [31:0]               len_eff;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && !q_full;
  assign win_next = {win[l2dec_pkg::TAPS-2:0], s_tdata};

  // Out-of-range lengths are clamped into the supported range.
  always_comb begin
    if (32'(cfg_wdata) < 32'(l2dec_pkg::MIN_LINE_LENGTH)) begin
      len_eff = 32'(l2dec_pkg::MIN_LINE_LENGTH);
    end else if (32'(cfg_wdata) > 32'(MAX_LINE_LENGTH)) begin
      len_eff = 32'(MAX_LINE_LENGTH);
    end else begin
      len_eff = 32'(cfg_wdata);
    end
    line_last_next = POS_W'(len_eff - 32'd1);
  end

  // A result is due on every even position from 4 on; the last sample of a
  // line closes out the final two results.
  always_comb begin
    emit = 1'b0;
    kind = l2dec_pkg::KIND_NORM;
    if (pos == line_last) begin
      emit = 1'b1;
      kind = line_last[0] ? l2dec_pkg::KIND_END_EVEN : l2dec_pkg::KIND_END_ODD;
    end else if (!pos[0] && pos >= POS_W'(4)) begin
      emit = 1'b1;
      if (pos == POS_W'(4)) begin
        kind = l2dec_pkg::KIND_FIRST;
      end else if (pos == POS_W'(6)) begin
        kind = l2dec_pkg::KIND_SECOND;
      end else begin
        kind = l2dec_pkg::KIND_NORM;
      end
    end
  end

  assign push_o.push       = accept && emit;
  assign push_o.entry.win  = win_next;
  assign push_o.entry.kind = kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      line_last <= POS_W'(l2dec_pkg::MIN_LINE_LENGTH - 1);
    end else if (cfg_wen) begin
      pos       <= '0;
      line_last <= line_last_next;
    end else if (accept) begin
      pos <= (pos == line_last) ? '0 : pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

endmodule

FILE: design/l2dec_queue.sv
module l2dec_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  l2dec_pkg::push_t     push_i,
  input  logic                 pop,
  output l2dec_pkg::entry_t    head,
  output l2dec_pkg::q_status_t status
);

  localparam int CNT_W = l2dec_pkg::QPTR_W + 1;

  l2dec_pkg::entry_t           entries [l2dec_pkg::QUEUE_DEPTH];
  logic [l2dec_pkg::QPTR_W-1:0] wr_ptr;
  logic [l2dec_pkg::QPTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]            count;

  assign head         = entries[rd_ptr];
  assign status.valid = (count != '0);
  assign status.full  = (count == CNT_W'(l2dec_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      entries[wr_ptr] <= push_i.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_i.push) begin
        wr_ptr <= wr_ptr + l2dec_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + l2dec_pkg::QPTR_W'(1);
      end
      case ({push_i.push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/l2dec_back.sv
module l2dec_back (
  input  logic                              clk,
  input  logic                              rst,
  input  l2dec_pkg::entry_t                 head,
  input  logic                              q_valid,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [l2dec_pkg::SAMPLE_BITS-1:0] m_tdata,
  output logic                              m_tlast
);

  localparam int SB = l2dec_pkg::SAMPLE_BITS;
  localparam int PAIRS = l2dec_pkg::TAPS / 2;

  logic                          sub;
  logic                          is_end;
  logic                          issue;
  logic                          rdy1, rdy2, rdy3, rdy4;
  logic                          v1, v2, v3;
  logic [l2dec_pkg::PAT_W-1:0]   pat;
  logic [l2dec_pkg::TAPS-1:0][l2dec_pkg::WIN_IDX_W-1:0] map;
  logic [SB-1:0]                 tap_val [l2dec_pkg::TAPS];
  logic signed [l2dec_pkg::PRE_W-1:0]  pre_d [PAIRS];

  logic signed [l2dec_pkg::PRE_W-1:0]  pre1 [PAIRS];
  logic                                last1;
  logic signed [l2dec_pkg::PROD_W-1:0] prod2 [PAIRS];
  logic                                last2;
  logic signed [l2dec_pkg::ACC_W-1:0]  acc;
  logic signed [l2dec_pkg::RND_W-1:0]  rnd3;
  logic                                last3;
  logic signed [l2dec_pkg::COEF_W-1:0] coef [PAIRS];

  assign coef[0] = l2dec_pkg::COEF0;
  assign coef[1] = l2dec_pkg::COEF1;
  assign coef[2] = l2dec_pkg::COEF2;
  assign coef[3] = l2dec_pkg::COEF3;

  assign rdy4 = !m_tvalid || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  // An end-of-line entry yields two results, so it stays at the head for two issues.
  assign is_end = (head.kind == l2dec_pkg::KIND_END_EVEN) ||
                  (head.kind == l2dec_pkg::KIND_END_ODD);
  assign issue  = q_valid && rdy1;
  assign pop    = issue && (!is_end || sub);

  always_comb begin
    case (head.kind)
      l2dec_pkg::KIND_NORM:     pat = l2dec_pkg::PAT_NORM;
      l2dec_pkg::KIND_FIRST:    pat = l2dec_pkg::PAT_FIRST;
      l2dec_pkg::KIND_SECOND:   pat = l2dec_pkg::PAT_SECOND;
      l2dec_pkg::KIND_END_EVEN: pat = sub ? l2dec_pkg::PAT_EVEN_B : l2dec_pkg::PAT_EVEN_A;
      l2dec_pkg::KIND_END_ODD:  pat = sub ? l2dec_pkg::PAT_ODD_B : l2dec_pkg::PAT_NORM;
      default:                  pat = l2dec_pkg::PAT_NORM;
    endcase
  end

  assign map = l2dec_pkg::pat_map(pat);

  always_comb begin
    for (int k = 0; k < l2dec_pkg::TAPS; k++) begin
      tap_val[k] = head.win[map[k]];
    end
    // The kernel is symmetric, so mirrored taps are added before the multiply.
    for (int k = 0; k < PAIRS; k++) begin
      pre_d[k] = l2dec_pkg::PRE_W'($signed(tap_val[k])) +
                 l2dec_pkg::PRE_W'($signed(tap_val[l2dec_pkg::TAPS-1-k]));
    end
  end

  always_comb begin
    acc = l2dec_pkg::ACC_W'(l2dec_pkg::ROUND_BIAS);
    for (int k = 0; k < PAIRS; k++) begin
      acc = acc + l2dec_pkg::ACC_W'(prod2[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub      <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (issue && is_end) begin
        sub <= !sub;
      end
      if (rdy1) begin
        v1 <= issue;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        m_tvalid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pre1  <= pre_d;
      last1 <= is_end && sub;
    end
    if (rdy2 && v1) begin
      for (int k = 0; k < PAIRS; k++) begin
        prod2[k] <= l2dec_pkg::PROD_W'(pre1[k]) * l2dec_pkg::PROD_W'(coef[k]);
      end
      last2 <= last1;
    end
    if (rdy3 && v2) begin
      // Arithmetic shift after the bias gives round to nearest, ties upward.
      rnd3  <= acc[l2dec_pkg::ACC_W-1:l2dec_pkg::FRAC_BITS];
      last3 <= last2;
    end
    if (rdy4 && v3) begin
      if (rnd3 > l2dec_pkg::RND_W'(l2dec_pkg::SAT_MAX)) begin
        m_tdata <= SB'(l2dec_pkg::SAT_MAX);
      end else if (rnd3 < l2dec_pkg::RND_W'(l2dec_pkg::SAT_MIN)) begin
        m_tdata <= SB'(l2dec_pkg::SAT_MIN);
      end else begin
        m_tdata <= SB'(rnd3);
      end
      m_tlast <= last3;
    end
  end

endmodule

FILE: design/lanczos2_decimate_by_two_unit.sv
// Lanczos-2 decimate-by-two for one line of signed samples. Samples enter on the
// s_ stream, one transaction per cycle at full rate unless the queue is full;
// each line of line_length samples (clamped to 8..MAX_LINE_LENGTH) yields
// floor(length/2) filtered results on the m_ stream, the last of the line
// marked by m_tlast. Edges are mirrored, results are rounded to nearest and
// saturated. The final two results of a line both follow the line's last
// sample. Throughput is set by the single multiply-accumulate pipeline, which
// takes one result per cycle while the output is not stalled, and by the
// four-entry queue in front of it that absorbs the end-of-line pair. Writing
// line_length restarts the line and must be done while the block is idle.
`include "lanczos2_decimate_by_two_unit_macros.svh"

module lanczos2_decimate_by_two_unit #(
  parameter int MAX_LINE_LENGTH = l2dec_pkg::MAX_LINE_LENGTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [l2dec_pkg::LEN_BITS-1:0]    cfg_wdata,  // line_length
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [l2dec_pkg::SAMPLE_BITS-1:0] s_tdata,    // sample
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [l2dec_pkg::SAMPLE_BITS-1:0] m_tdata,    // filtered
  output logic                              m_tlast     // last_of_line
);

  l2dec_pkg::push_t     push;
  l2dec_pkg::entry_t    head;
  l2dec_pkg::q_status_t q_status;
  logic                 pop;
  logic                 push_end;

  assign push_end = (push.entry.kind == l2dec_pkg::KIND_END_EVEN) ||
                    (push.entry.kind == l2dec_pkg::KIND_END_ODD);

  l2dec_front #(
    .MAX_LINE_LENGTH(MAX_LINE_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_status.full),
    .push_o   (push)
  );

  l2dec_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push_i(push),
    .pop   (pop),
    .head  (head),
    .status(q_status)
  );

  l2dec_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_valid (q_status.valid),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  `L2DEC_ASSERT_IMPLY(a_pop_needs_entry, pop, q_status.valid)
  `L2DEC_ASSERT_IMPLY(a_full_has_entry, q_status.full, q_status.valid)
  `L2DEC_ASSERT_NEXT(a_line_end_then_quiet, push.push && push_end, !push.push)

endmodule

FILE: sim/tb_lanczos2_decimate_by_two_unit.sv
module tb_lanczos2_decimate_by_two_unit;

  localparam int SB = l2dec_pkg::SAMPLE_BITS;
  localparam int LB = l2dec_pkg::LEN_BITS;

  typedef struct packed {
    logic [SB-1:0] value;
    logic          last;
  } decimated_t;

  // One row of the opening table. When typed is set, every result the row
  // causes must equal want; otherwise the predictor supplies the value.
  typedef struct packed {
    logic [SB-1:0] sample;
    logic          typed;
    logic [SB-1:0] want;
  } stim_row_t;

  localparam int OPENING_COUNT = 24;
  localparam int RANDOM_ITEMS = 860;
  localparam int CALM_ITEMS = 150;
  localparam int SETTLE_CYCLES = 12;
  localparam int BOUNDARY_COUNT = 8;

  localparam logic [SB-1:0] POS_FULL = 16'h7FFF;
  localparam logic [SB-1:0] NEG_FULL = 16'h8000;

  // Reset length is 8: two flat lines at the extremes, then a line built to
  // overflow the output range in both directions.
  localparam stim_row_t OPENING_ROWS [OPENING_COUNT] = '{
    '{POS_FULL, 1'b1, POS_FULL}, '{POS_FULL, 1'b1, POS_FULL},
    '{POS_FULL, 1'b1, POS_FULL}, '{POS_FULL, 1'b1, POS_FULL},
    '{POS_FULL, 1'b1, POS_FULL}, '{POS_FULL, 1'b1, POS_FULL},
    '{POS_FULL, 1'b1, POS_FULL}, '{POS_FULL, 1'b1, POS_FULL},
    '{NEG_FULL, 1'b1, NEG_FULL}, '{NEG_FULL, 1'b1, NEG_FULL},
    '{NEG_FULL, 1'b1, NEG_FULL}, '{NEG_FULL, 1'b1, NEG_FULL},
    '{NEG_FULL, 1'b1, NEG_FULL}, '{NEG_FULL, 1'b1, NEG_FULL},
    '{NEG_FULL, 1'b1, NEG_FULL}, '{NEG_FULL, 1'b1, NEG_FULL},
    '{POS_FULL, 1'b0, '0}, '{POS_FULL, 1'b0, '0},
    '{POS_FULL, 1'b0, '0}, '{NEG_FULL, 1'b0, '0},
    '{NEG_FULL, 1'b0, '0}, '{NEG_FULL, 1'b0, '0},
    '{NEG_FULL, 1'b0, '0}, '{POS_FULL, 1'b0, '0}
  };

  // Lengths at and beyond both clamps, odd lengths, and lines cut short by
  // a rewrite of the register.
  localparam logic [LB-1:0] BOUNDARY_LEN [BOUNDARY_COUNT] =
    '{13'd0, 13'd7, 13'd9, 13'd10, 13'd4097, 13'd8191, 13'd4096, 13'd8};
  localparam int BOUNDARY_ITEMS [BOUNDARY_COUNT] =
    '{13, 16, 18, 3, 30, 40, 20, 8};

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_wen = 1'b0;
  logic [LB-1:0] cfg_wdata = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [SB-1:0] s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b1;
  logic [SB-1:0] m_tdata;
  logic          m_tlast;

  logic          row_typed = 1'b0;
  logic [SB-1:0] row_want = '0;

  bit calm = 1'b0;
  int gap_odds = 0;
  int ready_odds = 0;
  int stall_left = 0;

  // Shadow of the block: line length, the last eight samples (newest first),
  // the first four samples of the line, and the two positions.
  logic [LB-1:0]        line_len;
  logic signed [SB-1:0] recent [l2dec_pkg::TAPS];
  logic signed [SB-1:0] line_head [4];
  int unsigned          next_in;
  int unsigned          next_out;
  decimated_t           due_outputs [$];
  int                   mismatches = 0;

  lanczos2_decimate_by_two_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),  // line_length
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // sample
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // filtered
    .m_tlast   (m_tlast)     // last_of_line
  );

  always #2 clk = ~clk;

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned active_length();
    int unsigned n;
    n = line_len;
    if (n < l2dec_pkg::MIN_LINE_LENGTH) n = l2dec_pkg::MIN_LINE_LENGTH;
    if (n > l2dec_pkg::MAX_LINE_LENGTH_DEFAULT) n = l2dec_pkg::MAX_LINE_LENGTH_DEFAULT;
    return n;
  endfunction

  // Reads line index i with the edges mirrored back into the line.
  function automatic logic signed [SB-1:0] mirrored_sample(input int i, input int len,
                                                           input int pos);
    int d;
    if (i < 0) i = -i;
    if (i >= len) i = 2 * len - 1 - i;
    if (i < 4) return line_head[i];
    d = pos - i;
    if (d < 0 || d > l2dec_pkg::TAPS - 1) return '0;
    return recent[d];
  endfunction

  function automatic logic [SB-1:0] lanczos_point(input int x, input int len,
                                                  input int pos);
    longint kernel [l2dec_pkg::TAPS];
    longint acc;
    longint r;
    int k;
    kernel = '{l2dec_pkg::COEF0, l2dec_pkg::COEF1, l2dec_pkg::COEF2, l2dec_pkg::COEF3,
               l2dec_pkg::COEF3, l2dec_pkg::COEF2, l2dec_pkg::COEF1, l2dec_pkg::COEF0};
    acc = 0;
    for (k = 0; k < l2dec_pkg::TAPS; k++)
      acc += kernel[k] * longint'(mirrored_sample(2 * x + k - 3, len, pos));
    // Arithmetic shift floors, so ties round toward plus infinity.
    r = (acc + l2dec_pkg::ROUND_BIAS) >>> l2dec_pkg::FRAC_BITS;
    if (r > l2dec_pkg::SAT_MAX) r = l2dec_pkg::SAT_MAX;
    if (r < l2dec_pkg::SAT_MIN) r = l2dec_pkg::SAT_MIN;
    return r[SB-1:0];
  endfunction

  task automatic decimate_sample(input logic [SB-1:0] s, input logic typed,
                                 input logic [SB-1:0] want);
    int unsigned len;
    int unsigned pos;
    int unsigned nout;
    int n;
    int k;
    decimated_t d;
    len = active_length();
    pos = next_in;
    nout = len / 2;
    n = 0;
    if (pos >= len) begin
      pos = 0;
      next_out = 0;
    end
    for (k = l2dec_pkg::TAPS - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = s;
    if (pos < 4) line_head[pos] = s;
    // Results leave as soon as their rightmost sample is in; the ones that
    // reach past the end of the line all leave on its last sample.
    while (n < 2 && next_out < nout && (2 * next_out + 4 <= pos || pos == len - 1)) begin
      d.value = typed ? want : lanczos_point(next_out, len, pos);
      d.last = (next_out == nout - 1);
      due_outputs.push_back(d);
      n++;
      next_out++;
    end
    if (pos == len - 1) begin
      next_in = 0;
      next_out = 0;
    end else begin
      next_in = pos + 1;
    end
  endtask

  task automatic check_result(input logic [SB-1:0] got, input logic got_last);
    decimated_t d;
    if (due_outputs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: got %0d last %0b", $signed(got), got_last);
    end else begin
      d = due_outputs.pop_front();
      if (got !== d.value || got_last !== d.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %0d last %0b, got %0d last %0b",
                   $signed(d.value), d.last, $signed(got), got_last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) decimate_sample(s_tdata, row_typed, row_want);
    if (!rst && m_tvalid && m_tready) check_result(m_tdata, m_tlast);
  end

  always @(negedge clk) begin
    if (stall_left != 0 && !calm) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && ready_odds != 0 && $urandom_range(ready_odds - 1, 0) == 0) begin
      stall_left <= $urandom_range(15, 0);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [SB-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(9, 0);
    case (r)
      0: return POS_FULL;
      1: return NEG_FULL;
      2: return '0;
      3, 4: return SB'($urandom_range(255, 0) - 128);
      default: return SB'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_sample(input logic [SB-1:0] v, input logic typed,
                             input logic [SB-1:0] want);
    if (!calm && gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    row_typed <= typed;
    row_want <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the sender off until every expected result is out, then lets any
  // sample still in the pipeline without a result drain as well.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_length_phase(input logic [LB-1:0] setting, input int count);
    int i;
    wait_drained();
    cfg_wen <= 1'b1;
    cfg_wdata <= setting;
    @(negedge clk);
    cfg_wen <= 1'b0;
    line_len = setting;
    next_in = 0;
    next_out = 0;
    if ($urandom_range(3, 0) == 0) begin
      gap_odds = 0;
      ready_odds = 0;
    end else begin
      gap_odds = $urandom_range(12, 2);
      ready_odds = $urandom_range(12, 2);
    end
    for (i = 0; i < count; i++) send_sample(pick_sample(), 1'b0, '0);
  endtask

  initial begin
    int i;
    int random_sent;
    int unsigned pick;
    int unsigned eff;
    int count;
    logic [LB-1:0] setting;

    line_len = LB'(l2dec_pkg::MIN_LINE_LENGTH);
    for (i = 0; i < l2dec_pkg::TAPS; i++) recent[i] = '0;
    for (i = 0; i < 4; i++) line_head[i] = '0;
    next_in = 0;
    next_out = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    gap_odds = 4;
    ready_odds = 4;
    for (i = 0; i < OPENING_COUNT; i++)
      send_sample(OPENING_ROWS[i].sample, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);

    for (i = 0; i < BOUNDARY_COUNT; i++) run_length_phase(BOUNDARY_LEN[i], BOUNDARY_ITEMS[i]);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(15, 0);
      if (pick == 0) setting = LB'($urandom_range(7, 0));
      else if (pick == 1) setting = LB'($urandom_range(160, 49));
      else setting = LB'($urandom_range(40, 8));
      eff = (setting < l2dec_pkg::MIN_LINE_LENGTH) ? l2dec_pkg::MIN_LINE_LENGTH : setting;
      count = $urandom_range(3, 1) * eff;
      // Now and then the line is cut short by the next register write.
      if ($urandom_range(3, 0) == 0) count += $urandom_range(eff - 1, 1);
      if (random_sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      run_length_phase(setting, count);
      random_sent += count;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && due_outputs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
